// ===== hw/rtl/mqrr_pkg.sv =====
package mqrr_pkg;

	// Default sizes of the queue array
	localparam int NUM_QUEUES_DEF  = 128;
	localparam int QUEUE_DEPTH_DEF = 16;

	// Fixed field widths of the transactions
	localparam int QID_W   = 7;
	localparam int TAG_W   = 8;
	localparam int CNT8_W  = 8;
	localparam int LEN_W   = 5;
	localparam int QID_NUM = 1 << QID_W;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_DONE   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STAT_APPENDED = 3'd0,
		STAT_KEPT     = 3'd1,
		STAT_REMOVED  = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	// One queue slot: tag and repeats still owed
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [CNT8_W-1:0] remaining;
	} slot_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic slot_rd;
		logic exec;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic out_full;
	} ctl_sts_t;

endpackage

// ===== hw/rtl/mqrr_cmd_if.sv =====
interface mqrr_cmd_if;
	import mqrr_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 operation;
	logic [QID_W-1:0]    queue_id;
	logic [TAG_W-1:0]    entry_tag;
	logic [CNT8_W-1:0]   repeat_count;

	modport source (
		output valid, operation, queue_id, entry_tag, repeat_count,
		input  ready
	);

	modport sink (
		input  valid, operation, queue_id, entry_tag, repeat_count,
		output ready
	);

endinterface

// ===== hw/rtl/mqrr_rsp_if.sv =====
interface mqrr_rsp_if;
	import mqrr_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [TAG_W-1:0]    served_tag;
	logic [CNT8_W-1:0]   left_count;
	logic [TAG_W-1:0]    next_tag;
	logic                next_valid;
	logic [LEN_W-1:0]    queue_length;

	modport source (
		output valid, status, served_tag, left_count, next_tag, next_valid, queue_length,
		input  ready
	);

	modport sink (
		input  valid, status, served_tag, left_count, next_tag, next_valid, queue_length,
		output ready
	);

endinterface

// ===== hw/rtl/mqrr_ctrl.sv =====
module mqrr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	output mqrr_pkg::ctl_cmd_t  ctl_cmd,
	input  mqrr_pkg::ctl_sts_t  ctl_sts
);
	import mqrr_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_PTR   = 4'b0100,
		S_EXEC  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Sequence: clearing pass after reset, then per command pointer read, slot read, update and result
	always_comb begin
		state_nxt = state_q;
		ctl_cmd   = '0;
		cmd_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ctl_cmd.clr_wr = 1'b1;
				if (ctl_sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl_cmd.accept = 1'b1;
					state_nxt      = S_PTR;
				end
			end
			S_PTR: begin
				ctl_cmd.slot_rd = 1'b1;
				state_nxt       = S_EXEC;
			end
			S_EXEC: begin
				// Hold until the result register can take the transaction
				if (!ctl_sts.out_full) begin
					ctl_cmd.exec = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== hw/rtl/mqrr_dpath.sv =====
module mqrr_dpath #(
	parameter int NUM_QUEUES  = mqrr_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = mqrr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mqrr_pkg::op_t                operation,
	input  logic [mqrr_pkg::QID_W-1:0]   queue_id,
	input  logic [mqrr_pkg::TAG_W-1:0]   entry_tag,
	input  logic [mqrr_pkg::CNT8_W-1:0]  repeat_count,
	input  mqrr_pkg::ctl_cmd_t           ctl_cmd,
	output mqrr_pkg::ctl_sts_t           ctl_sts,
	mqrr_rsp_if.source                   rsp
);
	import mqrr_pkg::*;

	localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int HW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int PW        = CW + 1;
	localparam int NUM_SLOTS = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW        = $clog2(NUM_SLOTS);
	localparam int PTR_W     = HW + CW;

	// Wrap a queue id into range; evaluated at elaboration only
	function automatic int wrap_id(input int id);
		int r;
		r = id;
		for (int k = 0; k < QID_NUM; k++) begin
			if (r >= NUM_QUEUES) begin
				r = r - NUM_QUEUES;
			end
		end
		return r;
	endfunction

	logic [QW-1:0] qmap [QID_NUM];

	for (genvar i = 0; i < QID_NUM; i++) begin : g_qmap
		assign qmap[i] = QW'(wrap_id(i));
	end

	// Latched transaction
	op_t               op_q;
	logic [QW-1:0]     q_q;
	logic [TAG_W-1:0]  tag_q;
	logic [CNT8_W-1:0] reps_q;

	always_ff @(posedge clk) begin
		if (ctl_cmd.accept) begin
			op_q   <= operation;
			q_q    <= qmap[queue_id];
			tag_q  <= entry_tag;
			reps_q <= repeat_count;
		end
	end

	// Clearing pass counter
	logic [QW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl_cmd.clr_wr) begin
			clr_q <= clr_q + QW'(1);
		end
	end

	assign ctl_sts.clr_last = (clr_q == QW'(NUM_QUEUES - 1));

	// Pointer memory: head index and entry count per queue
	logic [PTR_W-1:0] ptr_mem [NUM_QUEUES];
	logic [PTR_W-1:0] ptr_rd_q;
	logic [HW-1:0]    head;
	logic [CW-1:0]    cnt;
	logic [HW-1:0]    head_new;
	logic [CW-1:0]    cnt_new;
	logic             ptr_we;
	logic [QW-1:0]    ptr_wa;
	logic [PTR_W-1:0] ptr_wd;

	assign head = ptr_rd_q[PTR_W-1:CW];
	assign cnt  = ptr_rd_q[CW-1:0];

	assign ptr_we = ctl_cmd.clr_wr | ctl_cmd.exec;
	assign ptr_wa = ctl_cmd.clr_wr ? clr_q : q_q;
	assign ptr_wd = ctl_cmd.clr_wr ? '0 : {head_new, cnt_new};

	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[ptr_wa] <= ptr_wd;
		end
		if (ctl_cmd.accept) begin
			ptr_rd_q <= ptr_mem[qmap[queue_id]];
		end
	end

	// Slot addresses: head, head plus one, tail
	logic [AW-1:0] base;
	logic [HW:0]   head_p1;
	logic [HW-1:0] head_nx;
	logic [PW-1:0] tail_sum;
	logic [PW-1:0] tail_pos;
	logic [AW-1:0] addr_a;
	logic [AW-1:0] addr_b;
	logic [AW-1:0] addr_t;

	always_comb begin
		base     = AW'(AW'(q_q) * AW'(QUEUE_DEPTH));
		head_p1  = {1'b0, head} + (HW + 1)'(1);
		head_nx  = (head_p1 == (HW + 1)'(QUEUE_DEPTH)) ? '0 : head_p1[HW-1:0];
		tail_sum = PW'(head) + PW'(cnt);
		tail_pos = (tail_sum >= PW'(QUEUE_DEPTH)) ? tail_sum - PW'(QUEUE_DEPTH) : tail_sum;
		addr_a   = base + AW'(head);
		addr_b   = base + AW'(head_nx);
		addr_t   = base + AW'(tail_pos[HW-1:0]);
	end

	// Slot memory: two registered reads, one write
	slot_t         slot_mem [NUM_SLOTS];
	slot_t         slot_a_q;
	slot_t         slot_b_q;
	logic          slot_we;
	logic [AW-1:0] slot_wa;
	slot_t         slot_wd;

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (ctl_cmd.slot_rd) begin
			slot_a_q <= slot_mem[addr_a];
			slot_b_q <= slot_mem[addr_b];
		end
	end

	// Update: append or refuse when full; on done, answer empty, or serve and rotate, keep alone or remove
	status_t           res_status;
	logic [TAG_W-1:0]  res_served;
	logic [CNT8_W-1:0] res_left;
	logic [TAG_W-1:0]  res_next;
	logic [CNT8_W-1:0] rem_dec;
	logic              cnt_zero;
	logic              cnt_full;
	logic              cnt_multi;
	logic              wr_req;

	always_comb begin
		cnt_zero   = (cnt == '0);
		cnt_full   = (cnt >= CW'(QUEUE_DEPTH));
		cnt_multi  = (cnt > CW'(1));
		rem_dec    = (slot_a_q.remaining == '0) ? '0 : slot_a_q.remaining - CNT8_W'(1);
		res_status = STAT_EMPTY;
		res_served = '0;
		res_left   = '0;
		res_next   = '0;
		head_new   = head;
		cnt_new    = cnt;
		wr_req     = 1'b0;
		slot_wa    = addr_t;
		slot_wd    = '0;
		if (op_q == OP_APPEND) begin
			res_next = slot_a_q.tag;
			if (cnt_full) begin
				res_status = STAT_FULL;
			end else begin
				res_status        = STAT_APPENDED;
				wr_req            = 1'b1;
				slot_wd.tag       = tag_q;
				slot_wd.remaining = (reps_q == '0) ? CNT8_W'(1) : reps_q;
				cnt_new           = cnt + CW'(1);
				if (cnt_zero) begin
					res_next = tag_q;
				end
			end
		end else if (!cnt_zero) begin
			res_served        = slot_a_q.tag;
			res_left          = rem_dec;
			slot_wd.tag       = slot_a_q.tag;
			slot_wd.remaining = rem_dec;
			if (rem_dec != '0) begin
				res_status = STAT_KEPT;
				wr_req     = 1'b1;
				if (cnt_multi) begin
					head_new = head_nx;
					res_next = slot_b_q.tag;
				end else begin
					slot_wa  = addr_a;
					res_next = slot_a_q.tag;
				end
			end else begin
				res_status = STAT_REMOVED;
				head_new   = head_nx;
				cnt_new    = cnt - CW'(1);
				res_next   = cnt_multi ? slot_b_q.tag : '0;
			end
		end
		slot_we = wr_req & ctl_cmd.exec;
	end

	// Result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl_cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_cmd.exec) begin
			rsp.status       <= res_status;
			rsp.served_tag   <= res_served;
			rsp.left_count   <= res_left;
			rsp.next_tag     <= res_next;
			rsp.next_valid   <= (cnt_new != '0);
			rsp.queue_length <= LEN_W'(cnt_new);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign ctl_sts.out_full = out_valid_q & ~rsp.ready;

endmodule

// ===== hw/rtl/multi_queue_round_robin_repeat_core.sv =====
// Each command passes the pointer memory read, the dependent slot memory read and the write
// back of both with the result register load; that load waits while a result is stalled.
// A new command is taken only after the previous one has loaded the result register.
// Reset: arst_n clears control state and starts a clearing pass that empties every
// queue; no command is taken until it ends. Slot contents are not cleared.
module multi_queue_round_robin_repeat_core #(
	parameter int NUM_QUEUES  = mqrr_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = mqrr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mqrr_cmd_if.sink    cmd,
	mqrr_rsp_if.source  rsp
);
	import mqrr_pkg::*;

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;
	logic     ready;

	assign cmd.ready = ready;

	mqrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (ready),
		.ctl_cmd   (ctl_cmd),
		.ctl_sts   (ctl_sts)
	);

	mqrr_dpath #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (cmd.operation),
		.queue_id     (cmd.queue_id),
		.entry_tag    (cmd.entry_tag),
		.repeat_count (cmd.repeat_count),
		.ctl_cmd      (ctl_cmd),
		.ctl_sts      (ctl_sts),
		.rsp          (rsp)
	);

`ifndef ASSERT_OFF
	// A result is never loaded over one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.exec |-> !(rsp.valid && !rsp.ready))
		else $error("result register overwritten");

	// An accepted command reads its slots in the next cycle
	a_accept_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> ctl_cmd.slot_rd)
		else $error("slot read missing after accept");

	// An empty answer carries no entry
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STAT_EMPTY) |->
		(rsp.served_tag == '0 && !rsp.next_valid && rsp.queue_length == '0))
		else $error("empty answer carries data");

	// A refused append always leaves a nonempty queue
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STAT_FULL) |-> rsp.next_valid)
		else $error("full answer without head entry");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import mqrr_pkg::*;

	localparam int NQ          = NUM_QUEUES_DEF;
	localparam int DEPTH       = QUEUE_DEPTH_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 12;

	// One expected result transaction
	typedef struct packed {
		status_t           status;
		logic [TAG_W-1:0]  served_tag;
		logic [CNT8_W-1:0] left_count;
		logic [TAG_W-1:0]  next_tag;
		logic              next_valid;
		logic [LEN_W-1:0]  queue_length;
	} outcome_t;

	logic clk;
	logic arst_n;

	mqrr_cmd_if cmd_if ();
	mqrr_rsp_if rsp_if ();

	multi_queue_round_robin_repeat_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the queue array
	logic [TAG_W-1:0]  shadow_tag  [NQ*DEPTH];
	logic [CNT8_W-1:0] shadow_left [NQ*DEPTH];
	int                shadow_head [NQ];
	int                shadow_cnt  [NQ];

	outcome_t   outcome_q[$];
	int         err_cnt;
	int         quiet_cycles;
	bit         send_idle_en;
	bit         recv_idle_en;
	int         recv_hold;
	logic [6:0] hot_q [4];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int slot_index(int q, int pos);
		return q * DEPTH + (pos % DEPTH);
	endfunction

	// Apply one command to the shadow queues and return the result it must produce
	function automatic outcome_t apply_queue_op(op_t op, logic [QID_W-1:0] qid,
			logic [TAG_W-1:0] tag, logic [CNT8_W-1:0] reps);
		int                q;
		int                head;
		int                cnt;
		int                hs;
		int                ts;
		logic [CNT8_W-1:0] rem;
		outcome_t          o;
		q    = qid % NQ;
		head = shadow_head[q];
		cnt  = shadow_cnt[q];
		o    = '0;
		if (op == OP_APPEND) begin
			if (cnt >= DEPTH) begin
				o.status = STAT_FULL;
			end else begin
				ts = slot_index(q, head + cnt);
				shadow_tag[ts]  = tag;
				shadow_left[ts] = (reps == 0) ? 8'd1 : reps;
				cnt++;
				o.status = STAT_APPENDED;
			end
		end else if (cnt == 0) begin
			o.status = STAT_EMPTY;
		end else begin
			hs           = slot_index(q, head);
			rem          = shadow_left[hs];
			o.served_tag = shadow_tag[hs];
			rem          = (rem == 0) ? 8'd0 : rem - 8'd1;
			o.left_count = rem;
			if (rem != 0) begin
				o.status = STAT_KEPT;
				// Rotate to the tail unless the entry is alone
				if (cnt > 1) begin
					ts = slot_index(q, head + cnt);
					shadow_tag[ts]  = o.served_tag;
					shadow_left[ts] = rem;
					head = (head + 1) % DEPTH;
				end else begin
					shadow_left[hs] = rem;
				end
			end else begin
				o.status = STAT_REMOVED;
				head = (head + 1) % DEPTH;
				cnt--;
			end
		end
		shadow_head[q] = head;
		shadow_cnt[q]  = cnt;
		o.next_valid   = (cnt > 0);
		o.next_tag     = (cnt > 0) ? shadow_tag[slot_index(q, head)] : '0;
		o.queue_length = LEN_W'(cnt);
		return o;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Drive one command transaction and record its expected result on acceptance
	task automatic send_queue_op(op_t op, logic [QID_W-1:0] qid,
			logic [TAG_W-1:0] tag, logic [CNT8_W-1:0] reps);
		int gap;
		gap = (send_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			cmd_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_if.valid        <= 1'b1;
		cmd_if.operation    <= op;
		cmd_if.queue_id     <= qid;
		cmd_if.entry_tag    <= tag;
		cmd_if.repeat_count <= reps;
		do @(posedge clk); while (cmd_if.ready !== 1'b1);
		outcome_q.push_back(apply_queue_op(op, qid, tag, reps));
	endtask

	// Random command, biased by how full the target queue is
	task automatic send_random_op(bit focused);
		logic [QID_W-1:0]  qid;
		logic [CNT8_W-1:0] reps;
		op_t               op;
		int                r;
		int                fill;
		qid  = focused ? hot_q[$urandom_range(0, 3)] : QID_W'($urandom_range(0, QID_NUM - 1));
		fill = shadow_cnt[qid % NQ];
		r    = $urandom_range(0, 99);
		if (fill == 0)
			op = (r < 80) ? OP_APPEND : OP_DONE;
		else if (fill >= DEPTH)
			op = (r < 30) ? OP_APPEND : OP_DONE;
		else
			op = (r < 55) ? OP_APPEND : OP_DONE;
		r = $urandom_range(0, 99);
		if (r < 60)
			reps = CNT8_W'($urandom_range(1, 3));
		else if (r < 75)
			reps = 8'd0;
		else if (r < 90)
			reps = CNT8_W'($urandom_range(4, 20));
		else
			reps = CNT8_W'($urandom_range(200, 255));
		send_queue_op(op, qid, TAG_W'($urandom_range(0, 255)), reps);
	endtask

	task automatic pick_hot_queues();
		foreach (hot_q[i])
			hot_q[i] = QID_W'($urandom_range(0, QID_NUM - 1));
	endtask

	// Empty queue, zero count, removal of the last entry, kept entry alone
	task automatic test_single_entry();
		send_queue_op(OP_DONE,   7'd0, 8'h5A, 8'd7);
		send_queue_op(OP_APPEND, 7'd0, 8'h00, 8'd0);
		send_queue_op(OP_DONE,   7'd0, 8'h00, 8'd0);
		send_queue_op(OP_APPEND, 7'd0, 8'hFF, 8'd3);
		send_queue_op(OP_DONE,   7'd0, 8'h00, 8'hFF);
		send_queue_op(OP_DONE,   7'd0, 8'h00, 8'h00);
	endtask

	// Fill the top queue, refuse one more, then rotate the head
	task automatic test_fill_and_rotate();
		send_queue_op(OP_APPEND, 7'd127, 8'hFF, 8'hFF);
		for (int i = 1; i < DEPTH; i++)
			send_queue_op(OP_APPEND, 7'd127, TAG_W'(i * 17), CNT8_W'((i % 4) * 64 + 1));
		send_queue_op(OP_APPEND, 7'd127, 8'hAA, 8'd5);
		send_queue_op(OP_DONE,   7'd127, 8'h00, 8'd0);
		send_queue_op(OP_DONE,   7'd127, 8'h00, 8'd0);
		send_queue_op(OP_APPEND, 7'd127, 8'h3C, 8'd1);
	endtask

	// Random traffic on a few busy queues with idle stretches switched on and off
	task automatic test_random_mix(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) begin
				pick_hot_queues();
				send_idle_en = $urandom_range(0, 3) != 0;
				recv_idle_en = $urandom_range(0, 3) != 0;
			end
			send_random_op($urandom_range(0, 9) != 0);
		end
	endtask

	// Hold the result side off while commands keep coming
	task automatic test_backpressure(int n);
		pick_hot_queues();
		send_idle_en = 1'b0;
		recv_hold    = 400;
		for (int i = 0; i < n; i++)
			send_random_op(1'b1);
		send_idle_en = 1'b1;
	endtask

	// Random queue ids, about half across the whole range and the rest on the hot queues
	task automatic test_spread(int n);
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
		for (int i = 0; i < n; i++)
			send_random_op($urandom_range(0, 1) != 0);
	endtask

	// Result side ready with random stalls and forced hold-off
	initial begin
		int stall_left;
		stall_left   = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				recv_hold--;
				rsp_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				if (recv_idle_en && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (outcome_q.size() == 0) begin
				$error("unexpected result transaction: status %0d", rsp_if.status);
				err_cnt++;
			end else begin
				exp_o = outcome_q.pop_front();
				if (rsp_if.status !== exp_o.status) begin
					$error("status: expected %0d, actual %0d", exp_o.status, rsp_if.status);
					err_cnt++;
				end
				if (rsp_if.served_tag !== exp_o.served_tag) begin
					$error("served_tag: expected %0d, actual %0d",
						exp_o.served_tag, rsp_if.served_tag);
					err_cnt++;
				end
				if (rsp_if.left_count !== exp_o.left_count) begin
					$error("left_count: expected %0d, actual %0d",
						exp_o.left_count, rsp_if.left_count);
					err_cnt++;
				end
				if (rsp_if.next_tag !== exp_o.next_tag) begin
					$error("next_tag: expected %0d, actual %0d", exp_o.next_tag, rsp_if.next_tag);
					err_cnt++;
				end
				if (rsp_if.next_valid !== exp_o.next_valid) begin
					$error("next_valid: expected %0d, actual %0d",
						exp_o.next_valid, rsp_if.next_valid);
					err_cnt++;
				end
				if (rsp_if.queue_length !== exp_o.queue_length) begin
					$error("queue_length: expected %0d, actual %0d",
						exp_o.queue_length, rsp_if.queue_length);
					err_cnt++;
				end
			end
		end
	end

	// Abort when no transaction moves for too long
	always @(posedge clk) begin
		if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
				(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		err_cnt             = 0;
		quiet_cycles        = 0;
		send_idle_en        = 1'b1;
		recv_idle_en        = 1'b1;
		recv_hold           = 0;
		cmd_if.valid        = 1'b0;
		cmd_if.operation    = OP_APPEND;
		cmd_if.queue_id     = '0;
		cmd_if.entry_tag    = '0;
		cmd_if.repeat_count = '0;
		foreach (shadow_tag[i]) begin
			shadow_tag[i]  = '0;
			shadow_left[i] = '0;
		end
		foreach (shadow_head[i]) begin
			shadow_head[i] = 0;
			shadow_cnt[i]  = 0;
		end
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_entry();
		test_fill_and_rotate();
		test_random_mix(1000);
		test_backpressure(200);
		test_spread(400);

		// Drop valid, wait for the last results, then let the pipeline settle
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
